/* rtl/core/bfgl_pkg.sv */
// ----------------------------------------------------------------------------
// bfgl_pkg
// Shared types and constants of the font glyph lookup block: port widths,
// register indexes, register reset values, word kinds and the sequencer states.
// ----------------------------------------------------------------------------
package bfgl_pkg;

  localparam int unsigned AddrW    = 13;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRIMARY_BASE     = 3'd0,
    REG_SECONDARY_BASE   = 3'd1,
    REG_SECONDARY_ENABLE = 3'd2,
    REG_FONT_WIDTH       = 3'd3,
    REG_SPACING_GAP      = 3'd4
  } reg_idx_e;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [AddrW-1:0] PRIMARY_BASE_RST   = 13'd4;
  localparam logic [AddrW-1:0] SECONDARY_BASE_RST = 13'd0;
  localparam logic             SECONDARY_EN_RST   = 1'b0;
  localparam logic [ByteW-1:0] FONT_WIDTH_RST     = 8'd0;
  localparam logic [ByteW-1:0] SPACING_GAP_RST    = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_HDR_EVAL,
    ST_LEN0,
    ST_LEN1,
    ST_LEN2,
    ST_ENT0,
    ST_ENT1,
    ST_ENT2,
    ST_ENT3,
    ST_ENT4,
    ST_DONE
  } state_e;

endpackage

/* rtl/core/block_font_glyph_lookup_unit.sv */
// ----------------------------------------------------------------------------
// block_font_glyph_lookup_unit
// Byte-wide font memory with a sequencer that walks block records to find
// the jump entry of a character code and report its glyph.
// ----------------------------------------------------------------------------
// A write word (kind 0) stores one byte and leaves busy low. A lookup word
// (kind 1) raises busy until its result has been shown, while the sequencer
// reads record headers, steps over records that do not cover the code and
// reads the entry of the covering record. The font memory, one byte read per
// cycle through one shared address adder, paces the walk. The result is on
// the outputs while done_o is high and is held until the next lookup word is
// taken; the receiver must take it then. MEM_DEPTH must be a power of two,
// addresses wrap there.
// ----------------------------------------------------------------------------
module block_font_glyph_lookup_unit #(
  parameter int unsigned MEM_DEPTH  = 8192,
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bfgl_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bfgl_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind_i,
  input  logic [bfgl_pkg::AddrW-1:0]         mem_address_i,
  input  logic [bfgl_pkg::ByteW-1:0]         mem_byte_i,
  input  logic [bfgl_pkg::CodeW-1:0]         char_code_i,
  output logic                               done_o,
  output logic                               found_o,
  output logic [bfgl_pkg::ByteW-1:0]         glyph_width_o,
  output logic [bfgl_pkg::ByteW-1:0]         glyph_height_o,
  output logic [bfgl_pkg::ByteW-1:0]         glyph_spacing_o,
  output logic [bfgl_pkg::AddrW-1:0]         bitmap_address_o
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam int unsigned BW = $clog2(MAX_BLOCKS + 1);

  bfgl_pkg::state_e state_q, state_d;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata_q;

  logic [bfgl_pkg::AddrW-1:0] primary_base_q;
  logic [bfgl_pkg::AddrW-1:0] secondary_base_q;
  logic                       secondary_en_q;
  logic [7:0]                 font_width_q;
  logic [7:0]                 spacing_gap_q;

  logic [AW-1:0]  ptr_q, ptr_d;
  logic [7:0]     hi_q, hi_d;
  logic [7:0]     lo_q, lo_d;
  logic [7:0]     cnt_q, cnt_d;
  logic [7:0]     width_q, width_d;
  logic [7:0]     height_q, height_d;
  logic           found_q, found_d;
  logic           in_sec_q, in_sec_d;
  logic [BW-1:0]  blocks_q, blocks_d;
  logic [15:0]    code_q, code_d;

  logic                  accept;
  logic                  wr_en;
  logic [AW+12:0]        wr_addr_ext;
  logic [AW+12:0]        pbase_ext;
  logic [AW+12:0]        sbase_ext;
  logic [AW+15:0]        op_ext;
  logic [15:0]           add_op;
  logic [AW-1:0]         sum;
  logic [16:0]           diff;
  logic                  cnt_zero;
  logic                  hdr_hit;
  logic                  limit;
  logic                  go_secondary;
  logic [7:0]            cnt_m1;
  logic [bfgl_pkg::AddrW+AW-1:0] ptr_out_ext;

  assign accept      = start && !busy;
  assign wr_en       = accept && (kind_i == bfgl_pkg::KIND_WRITE);
  assign wr_addr_ext = {AW'(0), mem_address_i};
  assign pbase_ext   = {AW'(0), primary_base_q};
  assign sbase_ext   = {AW'(0), secondary_base_q};

  // record decode
  assign diff         = {1'b0, code_q} - {1'b0, hi_q, lo_q};
  assign cnt_zero     = (rdata_q == 8'd0);
  assign hdr_hit      = !diff[16] && (diff[15:8] == 8'd0) && (diff[7:0] < rdata_q);
  assign limit        = (blocks_q == BW'(MAX_BLOCKS));
  assign go_secondary = !in_sec_q && secondary_en_q;
  assign cnt_m1       = cnt_q - 8'd1;

  // shared address adder
  assign op_ext = {AW'(0), add_op};
  assign sum    = ptr_q + op_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr_ext[AW-1:0]] <= mem_byte_i;
    end
    rdata_q <= mem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primary_base_q   <= bfgl_pkg::PRIMARY_BASE_RST;
      secondary_base_q <= bfgl_pkg::SECONDARY_BASE_RST;
      secondary_en_q   <= bfgl_pkg::SECONDARY_EN_RST;
      font_width_q     <= bfgl_pkg::FONT_WIDTH_RST;
      spacing_gap_q    <= bfgl_pkg::SPACING_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfgl_pkg::REG_PRIMARY_BASE:     primary_base_q   <= cfg_wdata_i;
        bfgl_pkg::REG_SECONDARY_BASE:   secondary_base_q <= cfg_wdata_i;
        bfgl_pkg::REG_SECONDARY_ENABLE: secondary_en_q   <= cfg_wdata_i[0];
        bfgl_pkg::REG_FONT_WIDTH:       font_width_q     <= cfg_wdata_i[7:0];
        bfgl_pkg::REG_SPACING_GAP:      spacing_gap_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bfgl_pkg::ST_IDLE;
      found_q  <= 1'b0;
      in_sec_q <= 1'b0;
      blocks_q <= '0;
    end else begin
      state_q  <= state_d;
      found_q  <= found_d;
      in_sec_q <= in_sec_d;
      blocks_q <= blocks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    cnt_q    <= cnt_d;
    width_q  <= width_d;
    height_q <= height_d;
    code_q   <= code_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfgl_pkg::ST_IDLE: begin
        if (accept && (kind_i == bfgl_pkg::KIND_LOOKUP)) begin
          state_d = bfgl_pkg::ST_HDR0;
        end
      end
      bfgl_pkg::ST_HDR0:     state_d = limit ? bfgl_pkg::ST_DONE : bfgl_pkg::ST_HDR1;
      bfgl_pkg::ST_HDR1:     state_d = bfgl_pkg::ST_HDR2;
      bfgl_pkg::ST_HDR2:     state_d = bfgl_pkg::ST_HDR_EVAL;
      bfgl_pkg::ST_HDR_EVAL: begin
        if (cnt_zero) begin
          state_d = go_secondary ? bfgl_pkg::ST_HDR0 : bfgl_pkg::ST_DONE;
        end else if (hdr_hit) begin
          state_d = bfgl_pkg::ST_ENT0;
        end else begin
          state_d = bfgl_pkg::ST_LEN0;
        end
      end
      bfgl_pkg::ST_LEN0: state_d = bfgl_pkg::ST_LEN1;
      bfgl_pkg::ST_LEN1: state_d = bfgl_pkg::ST_LEN2;
      bfgl_pkg::ST_LEN2: state_d = bfgl_pkg::ST_HDR0;
      bfgl_pkg::ST_ENT0: state_d = bfgl_pkg::ST_ENT1;
      bfgl_pkg::ST_ENT1: state_d = bfgl_pkg::ST_ENT2;
      bfgl_pkg::ST_ENT2: state_d = bfgl_pkg::ST_ENT3;
      bfgl_pkg::ST_ENT3: state_d = bfgl_pkg::ST_ENT4;
      bfgl_pkg::ST_ENT4: state_d = bfgl_pkg::ST_DONE;
      bfgl_pkg::ST_DONE: state_d = bfgl_pkg::ST_IDLE;
      default:           state_d = bfgl_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ptr_d    = ptr_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    cnt_d    = cnt_q;
    width_d  = width_q;
    height_d = height_q;
    found_d  = found_q;
    in_sec_d = in_sec_q;
    blocks_d = blocks_q;
    code_d   = code_q;
    add_op   = 16'd1;
    unique case (state_q)
      bfgl_pkg::ST_IDLE: begin
        if (accept && (kind_i == bfgl_pkg::KIND_LOOKUP)) begin
          ptr_d    = pbase_ext[AW-1:0];
          code_d   = char_code_i;
          in_sec_d = 1'b0;
          blocks_d = '0;
          found_d  = 1'b0;
        end
      end
      bfgl_pkg::ST_HDR0: begin
        ptr_d   = sum;
        found_d = 1'b0;
      end
      bfgl_pkg::ST_HDR1: begin
        hi_d  = rdata_q;
        ptr_d = sum;
      end
      bfgl_pkg::ST_HDR2: begin
        lo_d  = rdata_q;
        ptr_d = sum;
      end
      bfgl_pkg::ST_HDR_EVAL: begin
        blocks_d = blocks_q + BW'(1);
        if (cnt_zero) begin
          if (go_secondary) begin
            in_sec_d = 1'b1;
            ptr_d    = sbase_ext[AW-1:0];
          end
        end else if (hdr_hit) begin
          add_op = {6'd0, diff[7:0], 2'b00};
          ptr_d  = sum;
          cnt_d  = rdata_q - diff[7:0];
        end else begin
          add_op = {6'd0, rdata_q, 2'b00};
          ptr_d  = sum;
        end
      end
      bfgl_pkg::ST_LEN0: ptr_d = sum;
      bfgl_pkg::ST_LEN1: begin
        hi_d  = rdata_q;
        ptr_d = sum;
      end
      bfgl_pkg::ST_LEN2: begin
        add_op = {hi_q, rdata_q};
        ptr_d  = sum;
      end
      bfgl_pkg::ST_ENT0: ptr_d = sum;
      bfgl_pkg::ST_ENT1: begin
        hi_d  = rdata_q;
        ptr_d = sum;
      end
      bfgl_pkg::ST_ENT2: begin
        lo_d  = rdata_q;
        ptr_d = sum;
      end
      bfgl_pkg::ST_ENT3: begin
        // step from entry + 3 to entry + 4 * remaining + 2
        width_d = rdata_q;
        add_op  = {6'd0, cnt_m1, 2'b11};
        ptr_d   = sum;
      end
      bfgl_pkg::ST_ENT4: begin
        height_d = rdata_q;
        add_op   = {hi_q, lo_q};
        ptr_d    = sum;
        found_d  = 1'b1;
      end
      bfgl_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // outputs
  assign ptr_out_ext      = {bfgl_pkg::AddrW'(0), ptr_q};
  assign busy             = (state_q != bfgl_pkg::ST_IDLE);
  assign done_o           = (state_q == bfgl_pkg::ST_DONE);
  assign found_o          = found_q;
  assign glyph_width_o    = found_q ? width_q : 8'd0;
  assign glyph_height_o   = found_q ? height_q : 8'd0;
  assign glyph_spacing_o  = (found_q && (width_q != 8'd0)) ? spacing_gap_q
                                                           : {1'b0, font_width_q[7:1]};
  assign bitmap_address_o = found_q ? ptr_out_ext[bfgl_pkg::AddrW-1:0] : primary_base_q;

endmodule

/* rtl/core/bfgl_checker.sv */
// ----------------------------------------------------------------------------
// bfgl_checker
// Port-level checks of the font glyph lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module bfgl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          kind_i,
  input logic                          done_o,
  input logic                          found_o,
  input logic [bfgl_pkg::ByteW-1:0]    glyph_width_o,
  input logic [bfgl_pkg::ByteW-1:0]    glyph_height_o
);

  // a result word is a single-cycle strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // a result only closes an accepted lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result while idle");

  // a lookup word keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == bfgl_pkg::KIND_LOOKUP)) |=> (busy && !done_o))
    else $error("lookup not started");

  // a write word gives no result and no busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == bfgl_pkg::KIND_WRITE)) |=> (!busy && !done_o))
    else $error("write word started a walk");

  // a miss reports an empty glyph
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> ((glyph_width_o == 8'd0) && (glyph_height_o == 8'd0)))
    else $error("miss with nonzero glyph size");

endmodule

bind block_font_glyph_lookup_unit bfgl_checker u_bfgl_checker (.*);
